>>> rtl/sawt_pkg.sv
// sawt_pkg: shared types and constants for the sliding ack window tracker.
// No dependencies; imported by every module of the block.
package sawt_pkg;

   // Sequence and window geometry
   localparam int SEQ_W       = 16;
   localparam int MASK_W      = 64;
   localparam int WINDOW_BITS = 64;
   localparam int SHAMT_W     = 7;

   typedef logic [SEQ_W-1:0]   seq_type;
   typedef logic [MASK_W-1:0]  mask_type;
   typedef logic [SHAMT_W-1:0] shamt_type;

   // Live window bits; positions at or above WINDOW_BITS are always zero
   localparam mask_type WMASK = (WINDOW_BITS >= MASK_W) ? {MASK_W{1'b1}} :
                                ((mask_type'(1) << WINDOW_BITS) - mask_type'(1));

   localparam seq_type  RESET_ACK  = {SEQ_W{1'b1}};
   localparam seq_type  HALF_RANGE = seq_type'(1) << (SEQ_W - 1);
   localparam seq_type  WIN_SEQ    = seq_type'(WINDOW_BITS);
   localparam shamt_type WIN_SHAMT = shamt_type'(WINDOW_BITS);

   // Window state carried between transfers
   typedef struct packed {
      seq_type  newest_ack;
      mask_type acked_bits;
      mask_type fresh_bits;
   } state_type;

   // One registered input transfer
   typedef struct packed {
      seq_type  new_ack;
      mask_type ack_mask;
      logic     track_loss;
   } item_type;

   // One result transfer
   typedef struct packed {
      seq_type  last_ack;
      logic     last_ack_fresh;
      mask_type acked_window;
      mask_type newly_acked_window;
      mask_type lost_window;
      seq_type  lost_base;
      seq_type  gap_lost_count;
   } result_type;

endpackage

>>> rtl/sawt_update.sv
// sawt_update: single-pass window update for one ack against the current state.
// Depends on sawt_pkg for the state, item and result types.
module sawt_update (
   input  sawt_pkg::item_type   item,
   input  sawt_pkg::state_type  state,
   output sawt_pkg::state_type  state_next,
   output sawt_pkg::result_type result
);
   import sawt_pkg::*;

   seq_type   diff_fwd;
   seq_type   diff_back;
   logic      is_dup;
   logic      is_newer;
   logic      old_in_win;
   mask_type  mask_in;
   shamt_type shamt_fwd;
   shamt_type shamt_back;
   logic [SHAMT_W-2:0] bit_fwd;
   logic [SHAMT_W-2:0] bit_back;
   logic      gap_big;
   mask_type  leaving;
   mask_type  slid;
   mask_type  slid_marked;
   mask_type  aligned;
   seq_type   gap_count;

   // Distances both ways and wraparound ordering
   always_comb begin
      diff_fwd   = item.new_ack - state.newest_ack;
      diff_back  = state.newest_ack - item.new_ack;
      is_dup     = (item.new_ack == state.newest_ack);
      is_newer   = ((item.new_ack > state.newest_ack) && (diff_fwd <= HALF_RANGE)) ||
                   ((item.new_ack < state.newest_ack) && (diff_back > HALF_RANGE));
      old_in_win = !is_dup && !is_newer && (diff_back <= WIN_SEQ);
      mask_in    = item.ack_mask & WMASK;
   end

   // Slide the window forward; clamp the shift at the window size
   always_comb begin
      shamt_fwd   = (diff_fwd >= WIN_SEQ) ? WIN_SHAMT : diff_fwd[SHAMT_W-1:0];
      bit_fwd     = diff_fwd[SHAMT_W-2:0] - (SHAMT_W-1)'(1);
      gap_big     = (diff_fwd > WIN_SEQ);
      leaving     = WMASK & ~(WMASK >> shamt_fwd);
      slid        = (state.acked_bits << shamt_fwd) & WMASK;
      slid_marked = gap_big ? '0 : (slid | ((mask_type'(1) << bit_fwd) & WMASK));
      gap_count   = diff_fwd - WIN_SEQ - seq_type'(1);
   end

   // Align an older ack onto the current window
   always_comb begin
      shamt_back = diff_back[SHAMT_W-1:0];
      bit_back   = diff_back[SHAMT_W-2:0] - (SHAMT_W-1)'(1);
      aligned    = ((mask_in << shamt_back) & WMASK) |
                   ((mask_type'(1) << bit_back) & WMASK);
   end

   // Select the update by ack ordering
   always_comb begin
      state_next = state;
      result     = '0;
      result.lost_base = state.newest_ack;
      if (is_dup) begin
         state_next.fresh_bits = mask_in & ~state.acked_bits;
         state_next.acked_bits = state.acked_bits | mask_in;
      end else if (is_newer) begin
         state_next.newest_ack = item.new_ack;
         state_next.fresh_bits = mask_in & ~slid_marked;
         state_next.acked_bits = slid_marked | mask_in;
         result.last_ack_fresh = 1'b1;
         if (item.track_loss) begin
            result.lost_window = leaving & ~state.acked_bits;
            if (gap_big) begin
               result.gap_lost_count = gap_count;
            end
         end
      end else if (old_in_win) begin
         state_next.fresh_bits = aligned & ~state.acked_bits;
         state_next.acked_bits = state.acked_bits | aligned;
      end
      result.last_ack           = state_next.newest_ack;
      result.acked_window       = state_next.acked_bits;
      result.newly_acked_window = state_next.fresh_bits;
   end

endmodule

>>> rtl/sliding_ack_window_tracker_core.sv
// sliding_ack_window_tracker_core: top level of the ack window tracker.
// Depends on sawt_pkg and sawt_update.
//
//   channel | direction | transfer when          | payload
//   req_    | in        | req_valid & req_ready | new_ack, ack_mask, track_loss
//   rsp_    | out       | rsp_valid & rsp_ready | last_ack .. gap_lost_count
//
// One result per ack, one ack per cycle while results are taken; each ack passes
// the input register, then the result register, with the window update in between.
// The window state updates as the result register loads, so the next ack
// sees it in the following cycle.
// Synchronous reset sets newest ack to 65535 and clears both masks.
// A stalled result holds; the input register keeps taking acks until both
// registers are full.
module sliding_ack_window_tracker_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sawt_pkg::seq_type      req_new_ack,
   input  sawt_pkg::mask_type     req_ack_mask,
   input  logic                   req_track_loss,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sawt_pkg::seq_type      rsp_last_ack,
   output logic                   rsp_last_ack_fresh,
   output sawt_pkg::mask_type     rsp_acked_window,
   output sawt_pkg::mask_type     rsp_newly_acked_window,
   output sawt_pkg::mask_type     rsp_lost_window,
   output sawt_pkg::seq_type      rsp_lost_base,
   output sawt_pkg::seq_type      rsp_gap_lost_count
);
   import sawt_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   item_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   logic       advance;

   // Move the held item into the result register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sawt_update u_update (
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // Valid bits for both registers
   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         in_valid_in  = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   // Hold control state; reset the window
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff.newest_ack <= RESET_ACK;
         state_ff.acked_bits <= '0;
         state_ff.fresh_bits <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture payloads on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.new_ack    <= req_new_ack;
         item_ff.ack_mask   <= req_ack_mask;
         item_ff.track_loss <= req_track_loss;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_last_ack           = result_ff.last_ack;
   assign rsp_last_ack_fresh     = result_ff.last_ack_fresh;
   assign rsp_acked_window       = result_ff.acked_window;
   assign rsp_newly_acked_window = result_ff.newly_acked_window;
   assign rsp_lost_window        = result_ff.lost_window;
   assign rsp_lost_base          = result_ff.lost_base;
   assign rsp_gap_lost_count     = result_ff.gap_lost_count;

endmodule

>>> rtl/sawt_checker.sv
// sawt_checker: port-level assertions for the ack window tracker, and its bind.
// Depends on sawt_pkg and the top level's ports.
module sawt_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  sawt_pkg::seq_type      req_new_ack,
   input  sawt_pkg::mask_type     req_ack_mask,
   input  logic                   req_track_loss,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sawt_pkg::seq_type      rsp_last_ack,
   input  logic                   rsp_last_ack_fresh,
   input  sawt_pkg::mask_type     rsp_acked_window,
   input  sawt_pkg::mask_type     rsp_newly_acked_window,
   input  sawt_pkg::mask_type     rsp_lost_window,
   input  sawt_pkg::seq_type      rsp_lost_base,
   input  sawt_pkg::seq_type      rsp_gap_lost_count
);
   import sawt_pkg::*;

   // A waiting ack holds valid and its payload until the transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_new_ack) &&
      $stable(req_ack_mask) && $stable(req_track_loss))
      else $error("ack changed while waiting");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last_ack) &&
      $stable(rsp_acked_window) && $stable(rsp_lost_window))
      else $error("result changed while stalled");

   // Newly acked positions are always acked
   a_fresh_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_newly_acked_window & ~rsp_acked_window) == '0)
      else $error("newly acked bit outside acked window");

   // The newest ack moves exactly on an advance; without one nothing is lost
   a_no_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_ack_fresh == (rsp_last_ack != rsp_lost_base)) &&
      (rsp_last_ack_fresh || (rsp_lost_window == '0 && rsp_gap_lost_count == '0)))
      else $error("loss or ack change without advance");

   // A jump beyond the window leaves only the incoming mask acked
   a_gap_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gap_lost_count != '0 |->
      rsp_last_ack_fresh && rsp_acked_window == rsp_newly_acked_window)
      else $error("window not cleared on large jump");

endmodule

bind sliding_ack_window_tracker_core sawt_checker u_sawt_checker (.*);

>>> tb/sv/sliding_ack_window_tracker_core_tb.sv
`timescale 1ns / 1ps
// sliding_ack_window_tracker_core_tb: self-checking bench for the ack window tracker.
// Depends on sawt_pkg and sliding_ack_window_tracker_core; keeps its own window model
// and checks every result transfer against it under random idling and back-pressure.
module sliding_ack_window_tracker_core_tb;
   import sawt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ACKS = 630;
   localparam mask_type ALL_ONES = {MASK_W{1'b1}};

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   seq_type  req_new_ack = '0;
   mask_type req_ack_mask = '0;
   logic     req_track_loss = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   seq_type  rsp_last_ack;
   logic     rsp_last_ack_fresh;
   mask_type rsp_acked_window;
   mask_type rsp_newly_acked_window;
   mask_type rsp_lost_window;
   seq_type  rsp_lost_base;
   seq_type  rsp_gap_lost_count;

   // Window model, advanced once per accepted ack
   seq_type  win_newest = RESET_ACK;
   mask_type win_acked = '0;
   mask_type win_fresh = '0;

   result_type pending_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold_request = 0;
   int rsp_hold_left = 0;

   sliding_ack_window_tracker_core i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_new_ack            (req_new_ack),
      .req_ack_mask           (req_ack_mask),
      .req_track_loss         (req_track_loss),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_last_ack           (rsp_last_ack),
      .rsp_last_ack_fresh     (rsp_last_ack_fresh),
      .rsp_acked_window       (rsp_acked_window),
      .rsp_newly_acked_window (rsp_newly_acked_window),
      .rsp_lost_window        (rsp_lost_window),
      .rsp_lost_base          (rsp_lost_base),
      .rsp_gap_lost_count     (rsp_gap_lost_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Wraparound compare: a distance of exactly half the range is newer only upward
   function automatic bit ack_is_newer(seq_type a, seq_type b);
      return ((a > b) && (int'(a) - int'(b) <= 32768)) ||
             ((a < b) && (int'(b) - int'(a) > 32768));
   endfunction

   // Apply one ack to the window model and return the result it causes
   function automatic result_type advance_ack_window(seq_type ack, mask_type mask,
                                                     logic track);
      result_type res;
      seq_type    ack_dist;
      int         steps;
      int         shamt;
      mask_type   aligned;
      res = '0;
      res.lost_base = win_newest;
      if (ack == win_newest) begin
         // duplicate: merge mask only
         win_fresh = mask & ~win_acked;
         win_acked = win_acked | mask;
      end else if (ack_is_newer(ack, win_newest)) begin
         // slide left, report what drops out, mark the old newest as acked
         ack_dist = ack - win_newest;
         steps = int'(ack_dist);
         shamt = (steps < WINDOW_BITS) ? steps : WINDOW_BITS;
         if (track) begin
            res.lost_window = ~(ALL_ONES >> shamt) & ~win_acked;
         end
         win_acked = win_acked << shamt;
         if (steps - 1 >= WINDOW_BITS) begin
            win_acked = '0;
            if (track) begin
               res.gap_lost_count = seq_type'(steps - 1 - WINDOW_BITS);
            end
         end else begin
            win_acked = win_acked | (mask_type'(1) << (steps - 1));
         end
         win_newest = ack;
         res.last_ack_fresh = 1'b1;
         win_fresh = mask & ~win_acked;
         win_acked = win_acked | mask;
      end else begin
         // older ack: align and merge if still inside the window
         ack_dist = win_newest - ack;
         steps = int'(ack_dist);
         if (steps <= WINDOW_BITS) begin
            aligned = (mask << steps) | (mask_type'(1) << (steps - 1));
            win_fresh = aligned & ~win_acked;
            win_acked = win_acked | aligned;
         end
      end
      res.last_ack = win_newest;
      res.acked_window = win_acked;
      res.newly_acked_window = win_fresh;
      return res;
   endfunction

   // Offer one ack, hold it until the transfer, then record its expected result
   task automatic send_ack(seq_type ack, mask_type mask, logic track);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_new_ack    <= ack;
      req_ack_mask   <= mask;
      req_track_loss <= track;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results = {pending_results, advance_ack_window(ack, mask, track)};
   endtask

   function automatic mask_type random_mask();
      case ($urandom_range(4))
         0: return '0;
         1: return ALL_ONES;
         2: return {$urandom, $urandom};
         3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default: return mask_type'($urandom_range(255));
      endcase
   endfunction

   // Mostly acks near the current newest, so slides, merges and losses all happen
   function automatic seq_type random_ack();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return win_newest + seq_type'($urandom_range(1, 8));
      if (pick < 40) return win_newest + seq_type'($urandom_range(9, 70));
      if (pick < 45) return win_newest + seq_type'($urandom_range(71, 32768));
      if (pick < 60) return win_newest;
      if (pick < 85) return win_newest - seq_type'($urandom_range(1, 64));
      if (pick < 90) return win_newest - seq_type'($urandom_range(65, 200));
      return seq_type'($urandom_range(65535));
   endfunction

   task automatic test_duplicates();
      send_ack(16'hFFFF, ALL_ONES, 1'b1);
      send_ack(16'hFFFF, '0, 1'b1);
   endtask

   task automatic test_slides();
      send_ack(16'd0, '0, 1'b1);
      send_ack(16'd64, '0, 1'b1);
      send_ack(16'd129, '0, 1'b1);
      send_ack(16'd1200, {$urandom, $urandom}, 1'b1);
      send_ack(16'd1205, '0, 1'b0);
      send_ack(16'd1269, '0, 1'b0);
   endtask

   task automatic test_older_acks();
      send_ack(16'd1268, ALL_ONES, 1'b1);
      send_ack(16'd1205, ALL_ONES, 1'b1);
      send_ack(16'd1204, ALL_ONES, 1'b1);
   endtask

   task automatic test_wrap_and_half_range();
      send_ack(16'd1270, 64'h8000_0000_0000_0001, 1'b1);
      send_ack(16'd34038, '0, 1'b1);
      send_ack(16'd1270, ALL_ONES, 1'b1);
      send_ack(16'd65535, ALL_ONES, 1'b1);
      send_ack(16'd0, '0, 1'b0);
      send_ack(16'd65500, ALL_ONES, 1'b1);
      send_ack(16'd100, {$urandom, $urandom}, 1'b1);
      send_ack(16'd36, '0, 1'b1);
      send_ack(16'd200, ALL_ONES, 1'b1);
   endtask

   task automatic test_random_traffic(int req_pct, int rsp_pct, int count);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) send_ack(random_ack(), random_mask(), $urandom_range(99) < 70);
   endtask

   // Stall results for a long stretch while acks keep coming
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_request = 300;
      repeat (40) send_ack(random_ack(), random_mask(), 1'($urandom_range(1)));
   endtask

   // Receiver: random stalls, plus a counted hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_hold_request != 0) begin
            rsp_hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left = rsp_hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: last_ack %h", rsp_last_ack);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("last_ack", 64'(want.last_ack), 64'(rsp_last_ack));
            check_field("last_ack_fresh", 64'(want.last_ack_fresh),
                        64'(rsp_last_ack_fresh));
            check_field("acked_window", want.acked_window, rsp_acked_window);
            check_field("newly_acked_window", want.newly_acked_window,
                        rsp_newly_acked_window);
            check_field("lost_window", want.lost_window, rsp_lost_window);
            check_field("lost_base", 64'(want.lost_base), 64'(rsp_lost_base));
            check_field("gap_lost_count", 64'(want.gap_lost_count),
                        64'(rsp_gap_lost_count));
         end
      end
   end

   // Abort on a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_duplicates();
      test_slides();
      test_older_acks();
      test_wrap_and_half_range();
      test_random_traffic(36, 79, RANDOM_ACKS);
      test_random_traffic(79, 36, RANDOM_ACKS);
      test_backpressure();
      test_random_traffic(0, 0, RANDOM_ACKS);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
